>>> design/bcd_convert_digit_shift_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the BCD convert and digit shift block
// Each macro expects clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef BCD_CONVERT_DIGIT_SHIFT_DEFINES_SVH
`define BCD_CONVERT_DIGIT_SHIFT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BCDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BCDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bcds_pkg.sv
// ----------------------------------------------------------------------------
// bcds_pkg
// Fixed widths, stage sizing and codes for the BCD convert and digit shift.
// ----------------------------------------------------------------------------
package bcds_pkg;

    // Field widths fixed by the interface
    localparam int VALUE_W   = 27;
    localparam int SHIFT_W   = 4;
    localparam int INDEX_W   = 4;
    localparam int DIGIT_W   = 4;
    localparam int BCD_OUT_W = 32;

    // Binary bits taken per double-dabble stage, digits per Horner stage
    localparam int BITS_PER_STAGE   = 4;
    localparam int DIGITS_PER_STAGE = 4;
    localparam int DAB_STAGES = (VALUE_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    // Function codes
    localparam logic FUNC_SHIFT_LEFT  = 1'b0;
    localparam logic FUNC_SHIFT_RIGHT = 1'b1;

    // Ten to the power n, for elaboration-time limits only
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] m;
        m = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            m = m * 64'd10;
        end
        return m;
    endfunction

endpackage

>>> design/bcd_convert_digit_shift.sv
// ----------------------------------------------------------------------------
// bcd_convert_digit_shift
// Binary to packed BCD, digit select and decimal digit shift, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: 9 + ceil(DIGITS/4) register stages: the capture stage, the
//   double-dabble stages, the digit shift stage and the Horner stages.
// Throughput: one transaction per cycle unless result_stall holds the pipe;
//   four binary bits per double-dabble stage, four digits per Horner stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "bcd_convert_digit_shift_defines.svh"

module bcd_convert_digit_shift
    import bcds_pkg::*;
#(
    parameter int DIGITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 func,
    input  logic [VALUE_W-1:0]   value,
    input  logic [SHIFT_W-1:0]   shift_digits,
    input  logic [INDEX_W-1:0]   digit_index,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [BCD_OUT_W-1:0] bcd_value,
    output logic [DIGIT_W-1:0]   selected_digit,
    output logic [VALUE_W-1:0]   shifted_value,
    output logic                 range_error
);

    localparam int          BW          = DIGIT_W * DIGITS;
    localparam logic [63:0] MAX_DEC     = pow10(DIGITS) - 64'd1;
    localparam int          HOR_STAGES  = (DIGITS + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;
    localparam int          SHIFT_STAGE = 1 + DAB_STAGES;
    localparam int          NSTAGES     = SHIFT_STAGE + 1 + HOR_STAGES;

    typedef struct packed {
        logic                 func;
        logic [SHIFT_W-1:0]   sh;
        logic [INDEX_W-1:0]   idx;
        logic                 err;
        logic [VALUE_W-1:0]   bin;
        logic [BW-1:0]        bcd;
        logic [BW-1:0]        sft;
        logic [DIGIT_W-1:0]   dig;
        logic [VALUE_W-1:0]   acc;
    } stage_t;

    stage_t stage_reg   [NSTAGES];
    logic   valid_reg   [NSTAGES];
    logic   stage_ready [NSTAGES+1];

    // One double-dabble step: correct every digit, then shift in one bit
    function automatic logic [BW-1:0] dabble_step(input logic [BW-1:0] b, input logic bit_in);
        logic [BW-1:0] t;
        t = b;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (t[DIGIT_W*i +: DIGIT_W] >= DIGIT_W'(5))
            begin
                t[DIGIT_W*i +: DIGIT_W] = t[DIGIT_W*i +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        return {t[BW-2:0], bit_in};
    endfunction

    // Every nibble of a result word is a decimal digit
    function automatic logic bcd_word_ok(input logic [BCD_OUT_W-1:0] w);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < BCD_OUT_W / DIGIT_W; i++)
        begin
            if (w[DIGIT_W*i +: DIGIT_W] > DIGIT_W'(9))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Ready chain: a stage advances when empty or when the next one advances
    assign stage_ready[NSTAGES] = !result_stall;
    assign item_stall           = !stage_ready[0];

    genvar k;
    generate
        for (k = 0; k < NSTAGES; k++)
        begin : g_stage
            stage_t stage_next;
            logic   valid_next;

            assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];

            if (k == 0)
            begin : g_capture
                // Capture the transaction and flag values out of range
                assign valid_next = item_valid;
                always_comb
                begin
                    stage_next      = '0;
                    stage_next.func = func;
                    stage_next.sh   = shift_digits;
                    stage_next.idx  = digit_index;
                    stage_next.bin  = value;
                    stage_next.err  = (64'(value) > MAX_DEC);
                end
            end
            else if (k < SHIFT_STAGE)
            begin : g_dabble
                // Convert the next group of binary bits, MSB first
                assign valid_next = valid_reg[k-1];
                always_comb
                begin
                    stage_next = stage_reg[k-1];
                    for (int s = 0; s < BITS_PER_STAGE; s++)
                    begin
                        if ((k - 1) * BITS_PER_STAGE + s < VALUE_W)
                        begin
                            stage_next.bcd = dabble_step(stage_next.bcd,
                                                         stage_next.bin[VALUE_W-1]);
                            stage_next.bin = {stage_next.bin[VALUE_W-2:0], 1'b0};
                        end
                    end
                end
            end
            else if (k == SHIFT_STAGE)
            begin : g_shift
                // Select the digit, shift by whole digits, zero on range error
                assign valid_next = valid_reg[k-1];
                always_comb
                begin
                    stage_next     = stage_reg[k-1];
                    stage_next.dig = '0;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        if ({1'b0, stage_next.idx} == (INDEX_W+1)'(i + 1))
                        begin
                            stage_next.dig = stage_next.bcd[DIGIT_W*i +: DIGIT_W];
                        end
                    end
                    if (stage_next.func == FUNC_SHIFT_RIGHT)
                    begin
                        stage_next.sft = stage_next.bcd >> {stage_next.sh, 2'b00};
                    end
                    else
                    begin
                        stage_next.sft = stage_next.bcd << {stage_next.sh, 2'b00};
                    end
                    stage_next.acc = '0;
                    if (stage_next.err)
                    begin
                        stage_next.bcd = '0;
                        stage_next.sft = '0;
                        stage_next.dig = '0;
                    end
                end
            end
            else
            begin : g_horner
                // Fold the next group of digits into the binary result, top first
                assign valid_next = valid_reg[k-1];
                always_comb
                begin
                    stage_next = stage_reg[k-1];
                    for (int s = 0; s < DIGITS_PER_STAGE; s++)
                    begin
                        if ((k - SHIFT_STAGE - 1) * DIGITS_PER_STAGE + s < DIGITS)
                        begin
                            stage_next.acc = (stage_next.acc << 3) + (stage_next.acc << 1)
                                + VALUE_W'(stage_next.sft[DIGIT_W * (DIGITS - 1
                                  - ((k - SHIFT_STAGE - 1) * DIGITS_PER_STAGE + s))
                                  +: DIGIT_W]);
                        end
                    end
                end
            end

            // Advance the valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_next;
                end
            end

            // Advance the payload; hold it while stalled
            always_ff @(posedge clk)
            begin
                if (stage_ready[k] && valid_next)
                begin
                    stage_reg[k] <= stage_next;
                end
            end
        end
    endgenerate

    // Drive the result from the last stage
    logic [63:0] bcd_ext;
    assign bcd_ext        = 64'(stage_reg[NSTAGES-1].bcd);
    assign result_valid   = valid_reg[NSTAGES-1];
    assign bcd_value      = bcd_ext[BCD_OUT_W-1:0];
    assign selected_digit = stage_reg[NSTAGES-1].dig;
    assign shifted_value  = stage_reg[NSTAGES-1].acc;
    assign range_error    = stage_reg[NSTAGES-1].err;

    // Checks
    `BCDS_ASSERT_NOW(a_range_zero, result_valid && range_error,
        bcd_value == '0 && selected_digit == '0 && shifted_value == '0,
        "range error result carries non-zero fields")
    `BCDS_ASSERT_NOW(a_bcd_digits, result_valid, bcd_word_ok(bcd_value),
        "bcd_value holds a nibble above nine")
    `BCDS_ASSERT_NOW(a_sel_digit, result_valid, selected_digit <= DIGIT_W'(9),
        "selected_digit above nine")
    `BCDS_ASSERT_NOW(a_stall_full, item_stall, valid_reg[0],
        "input stalled while first stage is empty")
    `BCDS_ASSERT_NEXT(a_accept_load, item_valid && !item_stall, valid_reg[0],
        "accepted transaction not captured")

endmodule

>>> dv/bcd_convert_digit_shift_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_convert_digit_shift_tb
// Self-checking bench for the BCD convert and digit shift pipeline. A queue of
// directed and random conversions feeds a bursty driver. An independent model
// predicts the BCD word, the selected digit and the shifted binary value, and
// the output monitor checks each transaction in order against that model.
// ----------------------------------------------------------------------------
module bcd_convert_digit_shift_tb
    import bcds_pkg::*;
();

    localparam int NUM_DIGITS    = 8;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int DRAIN_EVERY   = 500;
    localparam int HOLDOFF_AFTER = 500;
    localparam int HOLDOFF_LEN   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_LIMIT    = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [63:0] WORD_MASK =
        (NUM_DIGITS >= 16) ? '1 : ((64'd1 << (4 * NUM_DIGITS)) - 64'd1);

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
        logic [SHIFT_W-1:0] shift_digits;
        logic [INDEX_W-1:0] digit_index;
    } conv_req_t;

    typedef struct packed {
        logic [BCD_OUT_W-1:0] bcd_value;
        logic [DIGIT_W-1:0]   selected_digit;
        logic [VALUE_W-1:0]   shifted_value;
        logic                 range_error;
    } conv_res_t;

    typedef struct packed {
        conv_req_t req;
        logic      drain_first;
    } pending_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic                 func = FUNC_SHIFT_LEFT;
    logic [VALUE_W-1:0]   value = '0;
    logic [SHIFT_W-1:0]   shift_digits = '0;
    logic [INDEX_W-1:0]   digit_index = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [BCD_OUT_W-1:0] bcd_value;
    logic [DIGIT_W-1:0]   selected_digit;
    logic [VALUE_W-1:0]   shifted_value;
    logic                 range_error;

    pending_item_t pending_items[$];
    conv_res_t     expected_results[$];

    logic in_took = 1'b0;
    logic settling = 1'b0;
    int   total_items = 0;
    int   accepted_items = 0;
    int   results_checked = 0;
    int   range_items = 0;
    int   right_items = 0;
    int   error_count = 0;
    int   idle_cycles = 0;

    bcd_convert_digit_shift #(
        .DIGITS(NUM_DIGITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .func(func),
        .value(value),
        .shift_digits(shift_digits),
        .digit_index(digit_index),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .bcd_value(bcd_value),
        .selected_digit(selected_digit),
        .shifted_value(shifted_value),
        .range_error(range_error)
    );

    // Compute the expected conversion for one request
    function automatic conv_res_t predict_conversion(input conv_req_t req);
        conv_res_t   res;
        logic [63:0] top_decimal;
        logic [63:0] remaining;
        logic [63:0] bcd_word;
        logic [63:0] moved;
        logic [63:0] back;
        int          idx;
        res = '0;
        top_decimal = 64'd1;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            top_decimal = top_decimal * 64'd10;
        end
        top_decimal = top_decimal - 64'd1;
        if (64'(req.value) > top_decimal)
        begin
            res.range_error = 1'b1;
            return res;
        end
        // Split into decimal digits, least significant in the lowest nibble
        remaining = 64'(req.value);
        bcd_word = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            bcd_word[4*d +: 4] = 4'(remaining % 64'd10);
            remaining = remaining / 64'd10;
        end
        idx = int'(req.digit_index);
        if (idx >= 1 && idx <= NUM_DIGITS)
        begin
            res.selected_digit = bcd_word[4*(idx-1) +: 4];
        end
        // Shift by whole digits; a left shift drops digits above the top one
        if (req.func == FUNC_SHIFT_LEFT)
        begin
            moved = (bcd_word << (4 * int'(req.shift_digits))) & WORD_MASK;
        end
        else
        begin
            moved = bcd_word >> (4 * int'(req.shift_digits));
        end
        back = '0;
        for (int d = NUM_DIGITS - 1; d >= 0; d--)
        begin
            back = back * 64'd10 + 64'(moved[4*d +: 4]);
        end
        res.bcd_value = bcd_word[BCD_OUT_W-1:0];
        res.shifted_value = back[VALUE_W-1:0];
        return res;
    endfunction

    task automatic queue_item(input logic f, input logic [VALUE_W-1:0] v,
                              input logic [SHIFT_W-1:0] sh,
                              input logic [INDEX_W-1:0] idx, input logic drain);
        pending_item_t item;
        item.req.func = f;
        item.req.value = v;
        item.req.shift_digits = sh;
        item.req.digit_index = idx;
        item.drain_first = drain;
        pending_items.push_back(item);
    endtask

    // Generate the clock
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Hold reset, then release it at a falling edge
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Drive input transactions in bursts, holding the payload while stalled
    always @(negedge clk)
    begin
        pending_item_t head_item;
        int            burst_left;
        int            gap_left;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else if (!item_valid || in_took)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() == 0)
            begin
                item_valid <= 1'b0;
            end
            else if (pending_items[0].drain_first && expected_results.size() != 0)
            begin
                // Pause until the pipeline has emptied
                item_valid <= 1'b0;
            end
            else
            begin
                head_item = pending_items.pop_front();
                func <= head_item.req.func;
                value <= head_item.req.value;
                shift_digits <= head_item.req.shift_digits;
                digit_index <= head_item.req.digit_index;
                item_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(40, 1);
                    gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
        end
    end

    // Stall the output on a pattern of its own, with one long hold-off
    always @(negedge clk)
    begin
        int  mode;
        int  mode_left;
        int  stall_pct;
        int  holdoff_left;
        bit  holdoff_done;
        if (!rst_n || settling)
        begin
            result_stall <= 1'b0;
            if (!rst_n)
            begin
                mode_left = 0;
                holdoff_left = 0;
                holdoff_done = 1'b0;
            end
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            result_stall <= 1'b1;
        end
        else if (!holdoff_done && results_checked >= HOLDOFF_AFTER)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(2);
                mode_left = $urandom_range(60, 5);
                stall_pct = (mode == 0) ? 0 : ((mode == 1) ? 25 : 70);
            end
            mode_left = mode_left - 1;
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check results against the oldest expectation, then record new inputs
    always @(posedge clk)
    begin
        conv_res_t got;
        conv_res_t want;
        conv_req_t req;
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got.bcd_value = bcd_value;
                got.selected_digit = selected_digit;
                got.shifted_value = shifted_value;
                got.range_error = range_error;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: unexpected result bcd=%h digit=%0d shifted=%0d rerr=%b",
                                 got.bcd_value, got.selected_digit, got.shifted_value,
                                 got.range_error);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("ERROR: result %0d exp bcd=%h digit=%0d shifted=%0d rerr=%b",
                                     results_checked, want.bcd_value, want.selected_digit,
                                     want.shifted_value, want.range_error);
                            $display("       got bcd=%h digit=%0d shifted=%0d rerr=%b",
                                     got.bcd_value, got.selected_digit, got.shifted_value,
                                     got.range_error);
                        end
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                req.func = func;
                req.value = value;
                req.shift_digits = shift_digits;
                req.digit_index = digit_index;
                expected_results.push_back(predict_conversion(req));
                accepted_items++;
                if (req.func == FUNC_SHIFT_RIGHT)
                begin
                    right_items++;
                end
                if (predict_conversion(req).range_error)
                begin
                    range_items++;
                end
            end
            in_took <= item_valid && !item_stall;
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
                $display("bcd_convert_digit_shift test failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Build the stimulus, wait for it to drain and report
    initial
    begin
        logic [VALUE_W-1:0] v;
        logic [SHIFT_W-1:0] sh;
        logic [INDEX_W-1:0] idx;
        logic [63:0]        p;

        // Directed: field extremes, both directions, range and index edges
        queue_item(FUNC_SHIFT_LEFT, 0, 0, 1, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 99999999, 0, 8, 1'b0);
        queue_item(FUNC_SHIFT_RIGHT, 99999999, 8, 1, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 99999999, 8, 8, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 100000000, 3, 2, 1'b0);
        queue_item(FUNC_SHIFT_RIGHT, 134217727, 15, 15, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 12345678, 1, 0, 1'b0);
        queue_item(FUNC_SHIFT_RIGHT, 12345678, 1, 9, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 12345678, 7, 15, 1'b0);
        queue_item(FUNC_SHIFT_RIGHT, 12345678, 7, 4, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 87654321, 9, 3, 1'b0);
        queue_item(FUNC_SHIFT_RIGHT, 87654321, 15, 5, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 67108864, 2, 8, 1'b0);
        queue_item(FUNC_SHIFT_RIGHT, 90909090, 4, 7, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 1, 7, 8, 1'b1);
        queue_item(FUNC_SHIFT_RIGHT, 10000000, 7, 1, 1'b0);
        queue_item(FUNC_SHIFT_LEFT, 5, 8, 1, 1'b0);
        queue_item(FUNC_SHIFT_RIGHT, 24680135, 0, 6, 1'b0);

        // Random: mostly in range, with small values, decade edges and overflow
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(9))
                0: v = VALUE_W'($urandom_range(134217727, 100000000));
                1: v = VALUE_W'($urandom_range(999));
                2:
                begin
                    p = 64'd1;
                    repeat ($urandom_range(8, 1)) p = p * 64'd10;
                    v = VALUE_W'(p - 64'd1 + 64'($urandom_range(2)));
                end
                default: v = VALUE_W'($urandom_range(99999999));
            endcase
            sh = ($urandom_range(99) < 85) ? SHIFT_W'($urandom_range(8))
                                           : SHIFT_W'($urandom_range(15, 9));
            if ($urandom_range(99) < 80)
            begin
                idx = INDEX_W'($urandom_range(8, 1));
            end
            else
            begin
                idx = INDEX_W'($urandom_range(7));
                idx = (idx == 0) ? 4'd0 : idx + 4'd8;
            end
            queue_item(1'($urandom_range(1)), v, sh, idx,
                       (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
        end
        total_items = pending_items.size();

        // Wait for every transaction to be accepted and answered
        @(posedge rst_n);
        while (accepted_items < total_items) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        settling = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("ERROR: %0d expected results never arrived", expected_results.size());
        end

        $display("Ran %0d conversions (%0d right shifts, %0d out of range), %0d results checked",
                 accepted_items, right_items, range_items, results_checked);
        $display("Included a long output hold-off and drained pauses; %0d mismatches",
                 error_count);
        if (error_count == 0)
        begin
            $display("bcd_convert_digit_shift test passed");
        end
        else
        begin
            $display("bcd_convert_digit_shift test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/bcds_pkg.sv
design/bcd_convert_digit_shift.sv
dv/bcd_convert_digit_shift_tb.sv
